FILE: rtl/abms_pkg.sv
// Shared widths, codes, control types and the sigmoid table of the binned model scorer.
package abms_pkg;

  localparam int MAX_FEATURES    = 16;
  localparam int MAX_BINS        = 32;
  localparam int SIGMOID_ENTRIES = 1024;

  localparam int TABLE_DEPTH = MAX_FEATURES * MAX_BINS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FI_W        = 4;
  localparam int BI_W        = 5;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);
  localparam int POS_W       = 5;
  localparam int VAL_W       = 32;
  localparam int SCORE_W     = 24;
  localparam int LOGIT_W     = 32;
  localparam int PROB_W      = 16;
  localparam int ERR_W       = 2;
  localparam int FCOUNT_W    = 5;
  localparam int ENTRY_W     = 2 * VAL_W + SCORE_W;
  localparam int SIG_IDX_W   = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_PROD_W  = LOGIT_W + 2 + $clog2(SIGMOID_ENTRIES + 1);

  // Logit window of the table is [-8, 8) in Q16.16: offset 8.0, span 2^20.
  localparam int SIG_OFFSET     = 524288;
  localparam int SIG_SPAN_SHIFT = 20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'd1;

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_FEATURE = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MISMATCH = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACCUM,
    ST_INDEX,
    ST_LOOKUP,
    ST_RESULT
  } abms_state_t;

  typedef struct packed {
    logic load_we;
    logic feat_start;
    logic scan_run;
    logic accum;
    logic index;
    logic lookup;
    logic result_load;
  } abms_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } abms_status_t;

  typedef logic [PROB_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

  // Restoring long division by shift and subtract; table build only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at x = -8 + 16*i/N: e^-|x| by a Taylor series at |x|/256, squared
  // eight times, then rounded to Q0.16. Evaluated at elaboration only.
  function automatic logic [PROB_W-1:0] sig_entry(input int i);
    logic [63:0] one;
    logic [63:0] ad;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] e;
    logic [63:0] pn;
    logic [63:0] r;
    int d;
    one = 64'd1 << 31;
    d   = 2 * i - SIGMOID_ENTRIES;
    ad  = 64'((d < 0) ? -d : d);
    t   = (ad << 34) >> SIG_IDX_W;
    u   = t >> 8;
    u2  = (u * u) >> 31;
    u3  = (u2 * u) >> 31;
    u4  = (u3 * u) >> 31;
    e   = (one + (u2 >> 1) + udiv64(u4, 64'd24)) - (u + udiv64(u3, 64'd6));
    for (int k = 0; k < 8; k++) begin
      e = (e * e) >> 31;
    end
    pn = udiv64((e << 16) + ((one + e) >> 1), one + e);
    if (d < 0) begin
      return pn[PROB_W-1:0];
    end
    r = 64'd65536 - pn;
    return (r > 64'd65535) ? {PROB_W{1'b1}} : r[PROB_W-1:0];
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      rom[i] = sig_entry(i);
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

FILE: rtl/additive_binned_model_scorer.sv
// Top level of the additive binned model scorer: controller, datapath and checks.
//
// Use: first write the configuration (intercept, feature_count) through the
// cfg_write_en / cfg_index / cfg_data port, then send items on the input
// channel (item_valid / item_stall). A transfer takes place on a rising edge
// with valid high and stall low. A load item (kind 0) writes one bin into the
// bin table and gives no result; last_bin fixes the bin count.
// A feature item (kind 1) gives one result on the output channel
// (result_valid / result_stall): the matched score, and on the last feature
// of a prediction also the probability and an error code.
// A feature item's scan reads its feature's bins up to the match (at most
// MAX_BINS, none if its feature has no bins); one bin is read per cycle, then
// come accumulate, index, sigmoid lookup and result load. Input is stalled
// while a feature item is in work; the next item is taken in the cycle after
// the result load, even while that result still waits in the output register.
// When the receiver stalls, the result holds; a following feature item stops
// at its result stage until the register is free.
// Reset clears bin counts, the prediction position, running logit and the
// configuration; bin table contents stay undefined until loaded.
module additive_binned_model_scorer
  import abms_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SCORE_W-1:0]        cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic [FI_W-1:0]           feature_index,
  input  logic [BI_W-1:0]           bin_index,
  input  logic                      last_bin,
  input  logic signed [VAL_W-1:0]   bin_lower,
  input  logic signed [VAL_W-1:0]   bin_upper,
  input  logic signed [SCORE_W-1:0] bin_score,
  input  logic signed [VAL_W-1:0]   feature_value,
  input  logic                      last_feature,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [SCORE_W-1:0] contribution,
  output logic [PROB_W-1:0]         probability,
  output logic                      prediction_done,
  output logic [ERR_W-1:0]          error_code
);

  abms_cmd_t    cmd;
  abms_status_t status;

  // Sequence each item: accept, scan, accumulate, look up, deliver
  abms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (kind),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // Hold the bin table, the running prediction and the result register
  abms_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .feature_index   (feature_index),
    .bin_index       (bin_index),
    .last_bin        (last_bin),
    .bin_lower       (bin_lower),
    .bin_upper       (bin_upper),
    .bin_score       (bin_score),
    .feature_value   (feature_value),
    .last_feature    (last_feature),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .contribution    (contribution),
    .probability     (probability),
    .prediction_done (prediction_done),
    .error_code      (error_code)
  );

  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten before transfer");

  // A feature transfer makes the block busy in the next cycle
  a_busy_after_feature: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && kind == KIND_FEATURE) |=> item_stall)
    else $error("input not stalled while a feature is in work");

  // Intermediate results carry no probability and no error
  a_partial_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !prediction_done) |-> (probability == '0 && error_code == ERR_OK))
    else $error("partial result carries probability or error");

  // An error result carries no probability
  a_error_zero_prob: assert property (@(posedge clk) disable iff (rst)
    (result_valid && error_code != ERR_OK) |-> probability == '0)
    else $error("error result carries a probability");

endmodule

FILE: rtl/abms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module abms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/abms_ctrl.sv
// Sequencer of the binned model scorer: load, scan, accumulate, look up, deliver.
module abms_ctrl
  import abms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_kind,
  input  abms_status_t status,
  output abms_cmd_t    cmd,
  output logic         item_stall
);

  abms_state_t state;
  abms_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && item_kind == KIND_FEATURE) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM:  state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall     = 1'b0;
        cmd.load_we    = item_valid && item_kind == KIND_LOAD;
        cmd.feat_start = item_valid && item_kind == KIND_FEATURE;
      end
      ST_SCAN:   cmd.scan_run    = 1'b1;
      ST_ACCUM:  cmd.accum       = 1'b1;
      ST_INDEX:  cmd.index       = 1'b1;
      ST_LOOKUP: cmd.lookup      = 1'b1;
      ST_RESULT: cmd.result_load = status.out_free;
      default: begin
        cmd        = '0;
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/abms_datapath.sv
// Datapath: bin table, bin scan and compare, logit accumulator, sigmoid lookup, result register.
module abms_datapath
  import abms_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  abms_cmd_t                   cmd,
  output abms_status_t                status,
  input  logic                        cfg_write_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SCORE_W-1:0]          cfg_data,
  input  logic [FI_W-1:0]             feature_index,
  input  logic [BI_W-1:0]             bin_index,
  input  logic                        last_bin,
  input  logic signed [VAL_W-1:0]     bin_lower,
  input  logic signed [VAL_W-1:0]     bin_upper,
  input  logic signed [SCORE_W-1:0]   bin_score,
  input  logic signed [VAL_W-1:0]     feature_value,
  input  logic                        last_feature,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [SCORE_W-1:0]   contribution,
  output logic [PROB_W-1:0]           probability,
  output logic                        prediction_done,
  output logic [ERR_W-1:0]            error_code
);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Configuration
  logic signed [SCORE_W-1:0] intercept_q;
  logic [FCOUNT_W-1:0]       feat_count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      intercept_q  <= '0;
      feat_count_q <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_INTERCEPT:     intercept_q  <= cfg_data;
        REG_FEATURE_COUNT: feat_count_q <= cfg_data[FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bin table: {lower, upper, score} per entry
  logic               load_ok;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign load_ok   = 32'(feature_index) < MAX_FEATURES && 32'(bin_index) < MAX_BINS;
  assign ram_we    = cmd.load_we && load_ok;
  assign ram_waddr = ADDR_W'(32'(feature_index) * MAX_BINS + 32'(bin_index));

  abms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({bin_lower, bin_upper, bin_score}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bin counts per feature
  logic [CNT_W-1:0] bins_q [MAX_FEATURES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FEATURES; i++) begin
        bins_q[i] <= '0;
      end
    end else if (ram_we && last_bin) begin
      bins_q[FI_W'(feature_index)] <= CNT_W'(bin_index) + CNT_W'(1);
    end
  end

  // Prediction state
  logic [POS_W-1:0]          pos_q;
  logic signed [LOGIT_W-1:0] running_q;
  logic                      empty_q;

  // Scan
  logic signed [VAL_W-1:0]   val_q;
  logic                      last_q;
  logic [CNT_W-1:0]          n_q;
  logic [CNT_W-1:0]          n_sel;
  logic [CNT_W-1:0]          rd_cnt_q;
  logic [CNT_W-1:0]          cmp_idx_q;
  logic                      rd_vld_q;
  logic                      done_q;
  logic                      matched_q;
  logic signed [SCORE_W-1:0] score_q;
  logic                      issue;
  logic                      hit;
  logic signed [VAL_W-1:0]   rd_lower;
  logic signed [VAL_W-1:0]   rd_upper;
  logic signed [SCORE_W-1:0] rd_score;

  assign n_sel = (32'(pos_q) < MAX_FEATURES) ? bins_q[FI_W'(pos_q)] : '0;
  assign ram_raddr = ADDR_W'(32'(pos_q) * MAX_BINS + 32'(rd_cnt_q));
  assign issue = !done_q && rd_cnt_q < n_q;

  assign rd_lower = ram_rdata[ENTRY_W-1 -: VAL_W];
  assign rd_upper = ram_rdata[SCORE_W +: VAL_W];
  assign rd_score = ram_rdata[SCORE_W-1:0];
  assign hit      = val_q >= rd_lower && val_q < rd_upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q  <= 1'b0;
      done_q    <= 1'b1;
      matched_q <= 1'b0;
    end else if (cmd.feat_start) begin
      val_q     <= feature_value;
      last_q    <= last_feature;
      n_q       <= n_sel;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      done_q    <= (n_sel == '0);
      matched_q <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld_q  <= issue;
      cmp_idx_q <= rd_cnt_q;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      // first matching bin wins; on no match keep the last bin's score
      if (rd_vld_q && !done_q) begin
        if (hit) begin
          matched_q <= 1'b1;
          score_q   <= rd_score;
          done_q    <= 1'b1;
        end else if (cmp_idx_q == n_q - CNT_W'(1)) begin
          score_q <= rd_score;
          done_q  <= 1'b1;
        end
      end
    end
  end

  // Accumulate
  logic signed [SCORE_W-1:0] add_val;
  logic signed [LOGIT_W-1:0] base_logit;
  logic signed [LOGIT_W:0]   sum;
  logic signed [LOGIT_W-1:0] sum_sat;
  logic                      empty_now;
  logic [ERR_W-1:0]          err_calc;
  logic signed [LOGIT_W-1:0] logit_q;
  logic signed [SCORE_W-1:0] contrib_q;
  logic [ERR_W-1:0]          err_q;

  assign add_val    = (n_q == '0) ? '0 : score_q;
  assign base_logit = (pos_q == '0) ? LOGIT_W'(intercept_q) : running_q;
  assign sum        = (LOGIT_W+1)'(base_logit) + (LOGIT_W+1)'(add_val);
  assign empty_now  = empty_q || n_q == '0;

  always_comb begin
    if (sum[LOGIT_W] != sum[LOGIT_W-1]) begin
      sum_sat = sum[LOGIT_W] ? {1'b1, {(LOGIT_W-1){1'b0}}} : {1'b0, {(LOGIT_W-1){1'b1}}};
    end else begin
      sum_sat = sum[LOGIT_W-1:0];
    end
  end

  always_comb begin
    err_calc = ERR_OK;
    if (last_q) begin
      if ((POS_W+1)'(pos_q) + (POS_W+1)'(1) != (POS_W+1)'(feat_count_q)) begin
        err_calc = ERR_MISMATCH;
      end else if (empty_now) begin
        err_calc = ERR_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_q     <= '0;
      running_q <= '0;
      empty_q   <= 1'b0;
    end else if (cmd.accum) begin
      if (last_q) begin
        pos_q     <= '0;
        running_q <= '0;
        empty_q   <= 1'b0;
      end else begin
        running_q <= sum_sat;
        empty_q   <= empty_now;
        if (pos_q != POS_MAX) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      logit_q   <= sum_sat;
      contrib_q <= matched_q ? score_q : '0;
      err_q     <= err_calc;
    end
  end

  // Sigmoid index and lookup
  logic signed [LOGIT_W+1:0] sig_v;
  logic [SIG_PROD_W-1:0]     sig_prod;
  logic [SIG_PROD_W-1:0]     sig_scaled;
  logic [SIG_IDX_W-1:0]      sig_idx;
  logic [SIG_IDX_W-1:0]      idx_q;
  logic [PROB_W-1:0]         prob_q;

  assign sig_v      = (LOGIT_W+2)'(logit_q) + (LOGIT_W+2)'(SIG_OFFSET);
  assign sig_prod   = SIG_PROD_W'(sig_v[LOGIT_W:0]) * SIG_PROD_W'(SIGMOID_ENTRIES);
  assign sig_scaled = sig_prod >> SIG_SPAN_SHIFT;

  always_comb begin
    if (sig_v[LOGIT_W+1]) begin
      sig_idx = '0;
    end else if (sig_scaled >= SIG_PROD_W'(SIGMOID_ENTRIES)) begin
      sig_idx = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
    end else begin
      sig_idx = sig_scaled[SIG_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.index) begin
      idx_q <= sig_idx;
    end
    if (cmd.lookup) begin
      prob_q <= (last_q && err_q == ERR_OK) ? SIG_ROM[idx_q] : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      contribution    <= contrib_q;
      probability     <= prob_q;
      prediction_done <= last_q;
      error_code      <= err_q;
    end
  end

  assign status.scan_done = done_q;
  assign status.out_free  = !result_valid || !result_stall;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench of the additive binned model scorer, with its own scoring model.
`timescale 1ns / 1ps

module tb_top;
  import abms_pkg::*;

  // Let a generous multiple of the slowest correct run pass before giving up.
  localparam int CYCLE_LIMIT  = 400000;
  // Pause once the last result is in: one full scan plus the fixed pipeline.
  localparam int SETTLE_TICKS = MAX_BINS + 16;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct {
    logic                      kind;
    logic [FI_W-1:0]           feat;
    logic [BI_W-1:0]           bin;
    logic                      last_bin;
    logic signed [VAL_W-1:0]   lower;
    logic signed [VAL_W-1:0]   upper;
    logic signed [SCORE_W-1:0] score;
    logic signed [VAL_W-1:0]   value;
    logic                      last_feat;
  } scorer_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] contribution;
    logic [PROB_W-1:0]         probability;
    logic                      done;
    logic [ERR_W-1:0]          err;
  } score_result_t;

  // Block inputs, all known from time zero.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_INTERCEPT;
  logic [SCORE_W-1:0]        cfg_data = '0;
  logic                      item_valid = 1'b0;
  logic                      kind = KIND_LOAD;
  logic [FI_W-1:0]           feature_index = '0;
  logic [BI_W-1:0]           bin_index = '0;
  logic                      last_bin = 1'b0;
  logic signed [VAL_W-1:0]   bin_lower = '0;
  logic signed [VAL_W-1:0]   bin_upper = '0;
  logic signed [SCORE_W-1:0] bin_score = '0;
  logic signed [VAL_W-1:0]   feature_value = '0;
  logic                      last_feature = 1'b0;
  logic                      result_stall = 1'b0;

  // Block outputs.
  logic                      item_stall;
  logic                      result_valid;
  logic signed [SCORE_W-1:0] contribution;
  logic [PROB_W-1:0]         probability;
  logic                      prediction_done;
  logic [ERR_W-1:0]          error_code;

  // Scoring model state: bin tables, bin counts, prediction progress, registers.
  logic signed [VAL_W-1:0]   bin_lo [TABLE_DEPTH];
  logic signed [VAL_W-1:0]   bin_hi [TABLE_DEPTH];
  logic signed [SCORE_W-1:0] bin_sc [TABLE_DEPTH];
  bit                        bin_written [TABLE_DEPTH];
  int unsigned               bin_cnt [MAX_FEATURES];
  int unsigned               feat_pos = 0;
  int                        logit_acc = 0;
  bit                        no_bins_seen = 1'b0;
  int                        intercept_q = 0;
  int unsigned               fcount_q = 0;

  score_result_t             expected_scores [$];
  int unsigned               failures = 0;
  int unsigned               sent_items = 0;
  int unsigned               cycles = 0;
  // Quiet: neither side idles; used for calm phases and for the tail of the run.
  bit                        quiet = 1'b0;
  int unsigned               stall_left = 0;

  additive_binned_model_scorer dut (.*);

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Scoring model
  // ---------------------------------------------------------------------------

  // One sigmoid table point at x = -8 + 16*slot/N, worked out in Q1.31:
  // e^-|x| from a short Taylor series at |x|/256, squared eight times.
  function automatic logic [PROB_W-1:0] sigmoid_point(int slot);
    bit [63:0] unit_q31;
    bit [63:0] mag;
    bit [63:0] u;
    bit [63:0] u2;
    bit [63:0] u3;
    bit [63:0] u4;
    bit [63:0] ex;
    bit [63:0] p_neg;
    bit [63:0] p_pos;
    int        span;
    unit_q31 = 64'd1 << 31;
    span     = 2 * slot - SIGMOID_ENTRIES;
    mag      = (span < 0) ? 64'(-span) : 64'(span);
    u        = ((mag << 34) / 64'(SIGMOID_ENTRIES)) >> 8;
    u2       = (u * u) >> 31;
    u3       = (u2 * u) >> 31;
    u4       = (u3 * u) >> 31;
    ex       = (unit_q31 + u2 / 2 + u4 / 24) - (u + u3 / 6);
    for (int k = 0; k < 8; k++) begin
      ex = (ex * ex) >> 31;
    end
    p_neg = ((ex << 16) + (unit_q31 + ex) / 2) / (unit_q31 + ex);
    if (span < 0) begin
      return p_neg[PROB_W-1:0];
    end
    p_pos = 64'd65536 - p_neg;
    return (p_pos > 64'd65535) ? {PROB_W{1'b1}} : p_pos[PROB_W-1:0];
  endfunction

  // Map a Q16.16 logit onto the table window [-8, 8), clamping at both ends.
  function automatic logic [PROB_W-1:0] sigmoid_q16(longint logit_v);
    longint shifted;
    longint slot;
    shifted = logit_v + SIG_OFFSET;
    slot    = (shifted < 0) ? 0 : (shifted * SIGMOID_ENTRIES) >>> SIG_SPAN_SHIFT;
    if (slot > SIGMOID_ENTRIES - 1) begin
      slot = SIGMOID_ENTRIES - 1;
    end
    return sigmoid_point(int'(slot));
  endfunction

  function automatic void store_bin(scorer_item_t it);
    int unsigned a;
    a = int'(it.feat) * MAX_BINS + int'(it.bin);
    bin_lo[a]      = it.lower;
    bin_hi[a]      = it.upper;
    bin_sc[a]      = it.score;
    bin_written[a] = 1'b1;
    if (it.last_bin) begin
      bin_cnt[it.feat] = int'(it.bin) + 1;
    end
  endfunction

  // Score one feature value and queue the result it must produce.
  function automatic void score_value(scorer_item_t it);
    int unsigned   n;
    int unsigned   a;
    bit            hit;
    int            gain;
    longint        total;
    score_result_t r;
    n    = (feat_pos < MAX_FEATURES) ? bin_cnt[feat_pos] : 0;
    if (n > MAX_BINS) begin
      n = MAX_BINS;
    end
    hit  = 1'b0;
    gain = 0;
    r    = '0;
    r.err = ERR_OK;
    // First bin with lower <= value < upper wins.
    for (int unsigned k = 0; k < n && !hit; k++) begin
      a = feat_pos * MAX_BINS + k;
      if (it.value >= bin_lo[a] && it.value < bin_hi[a]) begin
        hit            = 1'b1;
        gain           = bin_sc[a];
        r.contribution = bin_sc[a];
      end
    end
    if (n == 0) begin
      no_bins_seen = 1'b1;
    end else if (!hit) begin
      gain = bin_sc[feat_pos * MAX_BINS + n - 1];
    end
    total = (feat_pos == 0) ? longint'(intercept_q) : longint'(logit_acc);
    total = total + gain;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
    end
    if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
    end
    if (it.last_feat) begin
      r.done = 1'b1;
      if (feat_pos + 1 != fcount_q) begin
        r.err = ERR_MISMATCH;
      end else if (no_bins_seen) begin
        r.err = ERR_EMPTY;
      end
      if (r.err == ERR_OK) begin
        r.probability = sigmoid_q16(total);
      end
      feat_pos     = 0;
      logit_acc    = 0;
      no_bins_seen = 1'b0;
    end else begin
      logit_acc = int'(total);
      if (feat_pos < 31) begin
        feat_pos++;
      end
    end
    expected_scores.insert(expected_scores.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders: fields the item kind ignores carry random bits
  // ---------------------------------------------------------------------------

  function automatic scorer_item_t bin_item(int f, int b, bit lb, int lo, int hi, int sc);
    scorer_item_t it;
    it.kind      = KIND_LOAD;
    it.feat      = FI_W'(f);
    it.bin       = BI_W'(b);
    it.last_bin  = lb;
    it.lower     = lo;
    it.upper     = hi;
    it.score     = SCORE_W'(sc);
    it.value     = $urandom;
    it.last_feat = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic scorer_item_t value_item(int v, bit lf);
    scorer_item_t it;
    it.kind      = KIND_FEATURE;
    it.feat      = FI_W'($urandom);
    it.bin       = BI_W'($urandom);
    it.last_bin  = 1'($urandom_range(0, 1));
    it.lower     = $urandom;
    it.upper     = $urandom;
    it.score     = SCORE_W'($urandom);
    it.value     = v;
    it.last_feat = lf;
    return it;
  endfunction

  // Pick a value for position p: mostly inside or on the edge of one of its bins.
  function automatic int pick_value(int unsigned p);
    int unsigned n;
    int unsigned a;
    longint      lo;
    longint      hi;
    n = (p < MAX_FEATURES) ? bin_cnt[p] : 0;
    if (n == 0 || $urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        default: return $urandom;
      endcase
    end
    a  = p * MAX_BINS + $urandom_range(0, n - 1);
    lo = bin_lo[a];
    hi = bin_hi[a];
    case ($urandom_range(0, 7))
      0:       return int'(lo);
      1:       return int'(hi);
      2:       return int'(hi - 1);
      3:       return int'(lo - 1);
      default: return (hi > lo) ? int'(lo + longint'($urandom) % (hi - lo)) : int'(lo);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the transfer, then advance the model.
  // Entered and left on a rising edge; valid stays high between back-to-back items.
  task automatic send_item(scorer_item_t it);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind          <= it.kind;
    feature_index <= it.feat;
    bin_index     <= it.bin;
    last_bin      <= it.last_bin;
    bin_lower     <= it.lower;
    bin_upper     <= it.upper;
    bin_score     <= it.score;
    feature_value <= it.value;
    last_feature  <= it.last_feat;
    item_valid    <= 1'b1;
    do @(posedge clk); while (item_stall);
    sent_items++;
    if (it.kind == KIND_LOAD) begin
      store_bin(it);
    end else begin
      score_value(it);
    end
  endtask

  // Drop valid, wait for every outstanding result, then let a last scan finish.
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only ever called while idle.
  task automatic write_config(int icpt, int unsigned count);
    logic signed [SCORE_W-1:0] icpt_bits;
    icpt_bits    = SCORE_W'(icpt);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_INTERCEPT;
    cfg_data     <= icpt_bits;
    @(posedge clk);
    cfg_index    <= REG_FEATURE_COUNT;
    cfg_data     <= SCORE_W'(count);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    intercept_q  = icpt_bits;
    fcount_q     = count & 32'h1F;
  endtask

  // Fill one feature table with ascending bins; some overlap, some are empty.
  task automatic load_table(int unsigned f, int unsigned nbins);
    longint cursor;
    longint width;
    longint lo;
    longint hi;
    int     sc;
    bit     narrow;
    narrow = $urandom_range(0, 1);
    cursor = narrow ? longint'(int'($urandom)) : -64'sd2147483648 + $urandom_range(0, 1 << 20);
    for (int unsigned k = 0; k < nbins; k++) begin
      width = narrow ? longint'($urandom_range(1, 1 << 16)) : longint'($urandom) / nbins + 1;
      lo    = cursor;
      hi    = cursor + width;
      case ($urandom_range(0, 7))
        0:       hi = lo - $urandom_range(0, 100);
        1:       lo = lo - width / 2;
        default: ;
      endcase
      if (hi > 64'sd2147483647) begin
        hi = 64'sd2147483647;
      end
      if (lo < -64'sd2147483648) begin
        lo = -64'sd2147483648;
      end
      case ($urandom_range(0, 7))
        0:       sc = -(1 << 23);
        1:       sc = (1 << 23) - 1;
        default: sc = $urandom;
      endcase
      send_item(bin_item(f, k, k == nbins - 1, int'(lo), int'(hi), sc));
      if (hi > cursor) begin
        cursor = hi + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 12) : 0);
      end
    end
  endtask

  // Overwrite one random bin; only fix a bin count once the bins below are all written.
  task automatic noise_load();
    int unsigned f;
    int unsigned b;
    bit          lb;
    f  = $urandom_range(0, MAX_FEATURES - 1);
    b  = $urandom_range(0, MAX_BINS - 1);
    lb = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < b; k++) begin
      if (!bin_written[f * MAX_BINS + k]) begin
        lb = 1'b0;
      end
    end
    send_item(bin_item(f, b, lb, $urandom, $urandom, $urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, none while quiet
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left--;
    end else if (stall_left == 1) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5);
      result_stall <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin
    score_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result contribution=%0d probability=%0d done=%0b err=%0d",
                 $time, contribution, probability, prediction_done, error_code);
        failures++;
      end else begin
        want = expected_scores.pop_front();
        if (contribution !== want.contribution || probability !== want.probability ||
            prediction_done !== want.done || error_code !== want.err) begin
          $display("%0t: mismatch expected contribution=%0d probability=%0d done=%0b err=%0d",
                   $time, want.contribution, want.probability, want.done, want.err);
          $display("%0t:          actual   contribution=%0d probability=%0d done=%0b err=%0d",
                   $time, contribution, probability, prediction_done, error_code);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No tables yet: empty features, count mismatch taking precedence, count of zero.
  task automatic test_empty_tables();
    write_config(0, 1);
    send_item(value_item($urandom, 1'b1));
    send_item(value_item($urandom, 1'b0));
    send_item(value_item($urandom, 1'b1));
    drain();
    write_config(0, 0);
    send_item(value_item($urandom, 1'b1));
  endtask

  // Bin search: bounds inclusive below and exclusive above, first match wins,
  // a gap falls back to the last bin's score, extreme values and scores.
  task automatic test_bin_matching();
    send_item(bin_item(0, 0, 1'b0, 32'h8000_0000, -1, -(1 << 23)));
    send_item(bin_item(0, 1, 1'b0, 0, 32'h0002_0000, (1 << 23) - 1));
    send_item(bin_item(0, 2, 1'b1, 32'h0001_0000, 32'h7FFF_FFFF, 1));
    drain();
    write_config(0, 1);
    send_item(value_item(32'h8000_0000, 1'b1));
    send_item(value_item(-2, 1'b1));
    send_item(value_item(-1, 1'b1));
    send_item(value_item(0, 1'b1));
    send_item(value_item(32'h0001_8000, 1'b1));
    send_item(value_item(32'h0001_FFFF, 1'b1));
    send_item(value_item(32'h0002_0000, 1'b1));
    send_item(value_item(32'h7FFF_FFFF, 1'b1));
  endtask

  // One catch-all bin of score zero, so the intercept alone sets the probability:
  // walk it across both clamps and both ends of the table window.
  task automatic test_sigmoid_edges();
    int points [8];
    points = '{-(1 << 23), -SIG_OFFSET - 1, -SIG_OFFSET, -1, 0,
               SIG_OFFSET - 1, SIG_OFFSET, (1 << 23) - 1};
    send_item(bin_item(0, 0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    foreach (points[i]) begin
      drain();
      write_config(points[i], 1);
      send_item(value_item($urandom, 1'b1));
    end
  endtask

  // Run the position past the tables and on to its saturation point.
  task automatic test_long_prediction();
    drain();
    write_config($urandom, MAX_FEATURES);
    for (int i = 0; i < 35; i++) begin
      send_item(value_item($urandom, i == 34));
    end
  endtask

  // Load every table, then run phases of mostly well-formed predictions with
  // random content, broken lengths and loads mixed in.
  task automatic test_random_traffic(int unsigned budget);
    int unsigned goal;
    int unsigned count;
    int unsigned len;
    int          icpt;
    goal = sent_items + budget;
    for (int unsigned f = 0; f < MAX_FEATURES; f++) begin
      load_table(f, (f == MAX_FEATURES - 1) ? MAX_BINS : $urandom_range(1, 6));
    end
    while (sent_items < goal) begin
      case ($urandom_range(0, 7))
        0:       count = 0;
        1:       count = MAX_FEATURES;
        default: count = $urandom_range(1, MAX_FEATURES);
      endcase
      case ($urandom_range(0, 7))
        0:       icpt = -(1 << 23);
        1:       icpt = (1 << 23) - 1;
        2, 3:    icpt = $urandom;
        default: icpt = int'($urandom_range(0, 24 << 16)) - (12 << 16);
      endcase
      drain();
      write_config(icpt, count);
      // Some phases run with no idling at all; the tail of the run never idles.
      quiet = (sent_items + 120 >= goal) || ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 10)) begin
        if (sent_items + 120 >= goal) begin
          quiet = 1'b1;
        end
        if ($urandom_range(0, 5) == 0) begin
          load_table($urandom_range(0, MAX_FEATURES - 1),
                     ($urandom_range(0, 9) == 0) ? MAX_BINS : $urandom_range(1, 6));
        end
        len = count;
        if (count == 0 || $urandom_range(0, 5) == 0) begin
          len = $urandom_range(1, 18);
        end
        for (int unsigned p = 0; p < len; p++) begin
          if (sent_items + 120 >= goal) begin
            quiet = 1'b1;
          end
          if ($urandom_range(0, 19) == 0) begin
            noise_load();
          end
          send_item(value_item(pick_value(p), p == len - 1));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_tables();
    test_bin_matching();
    test_sigmoid_edges();
    test_long_prediction();
    test_random_traffic(RANDOM_ITEMS);
    drain();
    if (failures == 0 && expected_scores.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
